FILE: rtl/bcu_pkg.sv
package bcu_pkg;

  // Field widths
  localparam int unsigned NW      = 6;
  localparam int unsigned BinW    = 60;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 64;

  // Largest accepted set size
  localparam int unsigned MaxN = 63;

  // Per-step factor width and widened product width
  localparam int unsigned FacW  = 12;
  localparam int unsigned ProdW = 76;

  // Iteration counts of the shared unit
  localparam int unsigned MulSteps = FacW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Operands handed to the multiply/divide unit
  typedef struct packed {
    logic [BinW-1:0] value;
    logic [FacW-1:0] num;
    logic [FacW-1:0] den;
  } bcu_op_t;

endpackage

FILE: rtl/bcu_muldiv.sv
module bcu_muldiv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  bcu_pkg::bcu_op_t       op_i,
  output logic                   done_o,
  output logic [bcu_pkg::BinW-1:0] quot_o
);
  import bcu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_DIV  = 3'b100
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [ProdW-1:0]  acc_q, acc_d;
  logic [FacW-1:0]   rem_q, rem_d;
  logic [BinW-1:0]   mcand_q, mcand_d;
  logic [FacW-1:0]   mplier_q, mplier_d;
  logic [FacW-1:0]   den_q, den_d;

  logic [ProdW-1:0]  addend;
  logic [FacW:0]     trial;
  logic [FacW-1:0]   diff;
  logic              fits;

  // Shift-add partial product and restoring divide trial
  assign addend = mplier_q[FacW-1] ? {{(ProdW-BinW){1'b0}}, mcand_q} : '0;
  assign trial  = {rem_q, acc_q[ProdW-1]};
  assign diff   = trial[FacW-1:0] - den_q;
  assign fits   = (trial >= {1'b0, den_q});

  // Sequence multiply bits MSB first, then quotient bits MSB first
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    rem_d    = rem_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    den_d    = den_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          acc_d    = '0;
          rem_d    = '0;
          mcand_d  = op_i.value;
          mplier_d = op_i.num;
          den_d    = op_i.den;
          cnt_d    = CntW'(MulSteps - 1);
          phase_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        acc_d    = {acc_q[ProdW-2:0], 1'b0} + addend;
        mplier_d = {mplier_q[FacW-2:0], 1'b0};
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          cnt_d   = CntW'(DivSteps - 1);
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        rem_d = fits ? diff : trial[FacW-1:0];
        acc_d = {acc_q[ProdW-2:0], fits};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    den_q    <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q[BinW-1:0];

endmodule

FILE: rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: returns the exact C(n,k) for a 6-bit n and k.
// Input stream: s_axis carries one item {k, n}; it is taken when tvalid and
// tready are both high. tready is high only while the unit is idle.
// Output stream: m_axis carries one 60-bit result per input item, held in an
// output register until the receiver takes it.
// The value starts at 1 and runs ceil(k/2) steps; each step multiplies by a
// falling pair of factors and divides exactly by a rising pair (one factor
// each in the last step when k is odd). Each step goes through one shared
// shift-add multiplier / restoring divider, which runs the multiply bits and
// then the quotient bits, with setup and handoff states around it.
// When k exceeds n the result is zero, and when k is zero it is one; both
// skip the shared unit and go straight to the done state. One item at a
// time: the unit returns to idle and takes the next item only after the
// result is loaded into the output register.
// A stalled receiver holds the result; a finished next result then waits
// inside the unit and no new item is taken until the register frees up.
// Reset clears the sequencer and the output valid; no item is in flight.
module binomial_coefficient_unit #(
  parameter int unsigned MaxN = bcu_pkg::MaxN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [5:0] total_items, [11:6] chosen_items, [15:12] zero
  input  logic [bcu_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [59:0] binomial, [63:60] zero
  output logic [bcu_pkg::OutDataW-1:0]    m_axis_tdata
);
  import bcu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_START = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [NW-1:0]   top_q, top_d;
  logic [NW-1:0]   bot_q, bot_d;
  logic [NW-1:0]   left_q, left_d;
  logic            odd_q, odd_d;
  logic [BinW-1:0] value_q, value_d;
  logic [FacW-1:0] num_q, num_d;
  logic [FacW-1:0] den_q, den_d;
  logic            out_valid_q, out_valid_d;
  logic [BinW-1:0] out_data_q, out_data_d;

  logic [NW-1:0]   in_n;
  logic [NW-1:0]   in_k;
  logic [NW-1:0]   in_steps;
  logic            accept;
  logic            single;
  logic [FacW-1:0] top_pair;
  logic [NW:0]     bot_next;
  logic [FacW-1:0] bot_pair;
  logic            unit_start;
  logic            unit_done;
  logic [BinW-1:0] unit_quot;
  bcu_op_t         unit_op;
  logic            load_out;

  assign in_n     = s_axis_tdata[NW-1:0];
  assign in_k     = s_axis_tdata[2*NW-1:NW];
  assign in_steps = NW'(({1'b0, in_k} + (NW+1)'(1)) >> 1);
  assign accept   = s_axis_tvalid && s_axis_tready;

  // Form the step factors
  assign single   = odd_q && (left_q == NW'(1));
  assign top_pair = {{(FacW-NW){1'b0}}, top_q} * {{(FacW-NW){1'b0}}, top_q - NW'(1)};
  assign bot_next = {1'b0, bot_q} + (NW+1)'(1);
  assign bot_pair = {{(FacW-NW-1){1'b0}}, bot_next} * {{(FacW-NW){1'b0}}, bot_q};

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // Sequence the steps over the shared unit
  always_comb begin
    state_d = state_q;
    top_d   = top_q;
    bot_d   = bot_q;
    left_d  = left_q;
    odd_d   = odd_q;
    value_d = value_q;
    num_d   = num_q;
    den_d   = den_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          top_d  = in_n;
          bot_d  = NW'(1);
          left_d = in_steps;
          odd_d  = in_k[0];
          if (({26'b0, in_n} > 32'(MaxN)) || (in_k > in_n)) begin
            value_d = '0;
            state_d = ST_DONE;
          end else if (in_k == '0) begin
            value_d = BinW'(1);
            state_d = ST_DONE;
          end else begin
            value_d = BinW'(1);
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        num_d   = single ? {{(FacW-NW){1'b0}}, top_q} : top_pair;
        den_d   = single ? {{(FacW-NW){1'b0}}, bot_q} : bot_pair;
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (unit_done) begin
          value_d = unit_quot;
          top_d   = top_q - NW'(2);
          bot_d   = bot_q + NW'(2);
          left_d  = left_q - NW'(1);
          state_d = (left_q == NW'(1)) ? ST_DONE : ST_SETUP;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    bot_q      <= bot_d;
    left_q     <= left_d;
    odd_q      <= odd_d;
    value_q    <= value_d;
    num_q      <= num_d;
    den_q      <= den_d;
    out_data_q <= out_data_d;
  end

  // Shared multiply / exact divide unit
  assign unit_start    = (state_q == ST_START);
  assign unit_op.value = value_q;
  assign unit_op.num   = num_q;
  assign unit_op.den   = den_q;

  bcu_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .op_i    (unit_op),
    .done_o  (unit_done),
    .quot_o  (unit_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-BinW){1'b0}}, out_data_q};

endmodule
